FILE: rtl/int_divide_remainder_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the integer divide and remainder unit
// Both macros sample on the rising edge of clk. The first is disabled
// while rst is high. The second also checks during reset.
// ----------------------------------------------------------------------------
`ifndef INT_DIVIDE_REMAINDER_UNIT_ASSERT_SVH
`define INT_DIVIDE_REMAINDER_UNIT_ASSERT_SVH

// Check a property outside reset
`define IDRU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every edge, reset included
`define IDRU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/idru_pkg.sv
// ----------------------------------------------------------------------------
// idru_pkg
// The shared width, operation codes and pipeline payload types of the
// integer divide and remainder unit.
// ----------------------------------------------------------------------------
package idru_pkg;

  // Operand and result width
  localparam int unsigned DW = 32;

  // Operation codes
  typedef enum logic [1:0] {
    FN_DIVU = 2'd0,
    FN_REMU = 2'd1,
    FN_DIV  = 2'd2,
    FN_REM  = 2'd3
  } func_t;

  // One input beat as held in the skid register
  typedef struct packed {
    logic [1:0]    func;
    logic [DW-1:0] dividend;
    logic [DW-1:0] divisor;
  } req_t;

  // Divider state carried from stage to stage
  typedef struct packed {
    logic          want_rem;  // deliver the remainder, not the quotient
    logic          neg_res;   // negate the selected result at the end
    logic [DW-1:0] rem;       // partial remainder
    logic [DW-1:0] nq;        // dividend bits shifting out, quotient bits in
    logic [DW-1:0] dvsr;      // divisor magnitude
  } stage_t;

endpackage

FILE: rtl/idru_req_if.sv
// ----------------------------------------------------------------------------
// idru_req_if
// Request channel of the divide unit: operation code and operands.
// ----------------------------------------------------------------------------
interface idru_req_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                func;
  logic [idru_pkg::DW-1:0]   dividend;
  logic [idru_pkg::DW-1:0]   divisor;

  modport source (output valid, func, dividend, divisor, input ready);
  modport sink   (input valid, func, dividend, divisor, output ready);
endinterface

FILE: rtl/idru_rsp_if.sv
// ----------------------------------------------------------------------------
// idru_rsp_if
// Response channel of the divide unit: one quotient or remainder per beat.
// ----------------------------------------------------------------------------
interface idru_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [idru_pkg::DW-1:0]   result;

  modport source (output valid, result, input ready);
  modport sink   (input valid, result, output ready);
endinterface

FILE: rtl/idru_step.sv
// ----------------------------------------------------------------------------
// idru_step
// One restoring division step: shift in the next dividend bit, subtract the
// divisor when it fits (or when the doubled remainder carried out), and
// shift the quotient bit in.
// ----------------------------------------------------------------------------
module idru_step (
  input  idru_pkg::stage_t cur,
  output idru_pkg::stage_t nxt
);

  logic                        carry;
  logic [idru_pkg::DW-1:0]     shifted;
  logic [idru_pkg::DW:0]       diff;
  logic                        fits;

  // Double the partial remainder and trial-subtract the divisor
  assign carry   = cur.rem[idru_pkg::DW-1];
  assign shifted = {cur.rem[idru_pkg::DW-2:0], cur.nq[idru_pkg::DW-1]};
  assign diff    = {carry, shifted} - {1'b0, cur.dvsr};
  assign fits    = ~diff[idru_pkg::DW];

  // Restore on a failed subtract, record the quotient bit
  always_comb begin
    nxt          = cur;
    nxt.rem      = fits ? diff[idru_pkg::DW-1:0] : shifted;
    nxt.nq       = {cur.nq[idru_pkg::DW-2:0], fits};
  end

endmodule

FILE: rtl/int_divide_remainder_unit.sv
// ----------------------------------------------------------------------------
// int_divide_remainder_unit
// 34 register stages lie between an accepted request beat and its response
//   beat: sign fixup, one stage per quotient bit, output register.
// Throughput: one beat per cycle; a stalled output freezes the pipe and a
//   skid register takes one more request. Reset empties all stages.
// ----------------------------------------------------------------------------
`include "int_divide_remainder_unit_assert.svh"

module int_divide_remainder_unit (
  input  logic              clk,
  input  logic              rst,
  idru_req_if.sink          req,
  idru_rsp_if.source        rsp
);

  localparam int unsigned DW = idru_pkg::DW;

  // Skid register in front of the pipe
  logic                     skid_vld;
  idru_pkg::req_t           skid;

  // Pipe stages: 0 is the sign fixup, 1..DW are the division steps
  logic                     vld [DW+1];
  idru_pkg::stage_t         stg [DW+1];
  idru_pkg::stage_t         step_out [DW];

  // Output register
  logic                     rsp_vld;
  logic [DW-1:0]            res;

  logic                     en;
  idru_pkg::req_t           src;
  logic                     src_vld;
  idru_pkg::func_t          fn;
  logic                     want_rem;
  logic                     is_signed;
  logic                     a_neg;
  logic                     b_neg;
  logic                     b_zero;
  idru_pkg::stage_t         pre;
  logic [DW-1:0]            sel;
  logic [DW-1:0]            fixed;

  // Advance the whole pipe unless the output beat is stalled
  assign en        = ~rsp_vld | rsp.ready;
  assign req.ready = ~skid_vld;

  // Pick the held beat first, else the incoming one
  always_comb begin
    if (skid_vld) begin
      src = skid;
    end else begin
      src = '{func: req.func, dividend: req.dividend, divisor: req.divisor};
    end
  end
  assign src_vld = skid_vld | req.valid;

  // Decode the operation and take operand magnitudes
  assign fn        = idru_pkg::func_t'(src.func);
  assign want_rem  = (fn == idru_pkg::FN_REMU) || (fn == idru_pkg::FN_REM);
  assign is_signed = (fn == idru_pkg::FN_DIV) || (fn == idru_pkg::FN_REM);
  assign a_neg     = is_signed & src.dividend[DW-1];
  assign b_neg     = is_signed & src.divisor[DW-1];
  assign b_zero    = (src.divisor == '0);

  always_comb begin
    pre.want_rem = want_rem;
    // Quotient by zero stays all ones; remainder by zero comes back as
    // the dividend through a double negation
    if (want_rem) begin
      pre.neg_res = a_neg;
    end else begin
      pre.neg_res = (a_neg ^ b_neg) & ~b_zero;
    end
    pre.rem  = '0;
    pre.nq   = a_neg ? ({DW{1'b0}} - src.dividend) : src.dividend;
    pre.dvsr = b_neg ? ({DW{1'b0}} - src.divisor) : src.divisor;
  end

  // Hold a beat that arrives while the pipe is frozen, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_vld <= 1'b0;
    end else if (skid_vld && en) begin
      skid_vld <= 1'b0;
    end else if (!skid_vld && req.valid && !en) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_vld && req.valid && !en) begin
      skid <= '{func: req.func, dividend: req.dividend, divisor: req.divisor};
    end
  end

  // Load the sign fixup stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= src_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg[0] <= pre;
    end
  end

  // One restoring step per stage
  for (genvar k = 1; k <= DW; k++) begin : g_step
    idru_step u_step (
      .cur (stg[k-1]),
      .nxt (step_out[k-1])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg[k] <= step_out[k-1];
      end
    end
  end

  // Select quotient or remainder and apply the sign
  assign sel   = stg[DW].want_rem ? stg[DW].rem : stg[DW].nq;
  assign fixed = stg[DW].neg_res ? ({DW{1'b0}} - sel) : sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_vld <= 1'b0;
    end else if (en) begin
      rsp_vld <= vld[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= fixed;
    end
  end

  assign rsp.valid  = rsp_vld;
  assign rsp.result = res;

  // Reset leaves no beat in the skid, the first stage or the output
  `IDRU_ASSERT_ALWAYS(a_reset_empty, rst |=> (!skid_vld && !vld[0] && !rsp_vld), "pipe not empty after reset")
  // A held beat moves into the pipe as soon as the pipe advances
  `IDRU_ASSERT(a_skid_drain, (skid_vld && en) |=> (vld[0] && !skid_vld), "skid beat not drained")
  // The skid only fills while the output is stalled
  `IDRU_ASSERT(a_skid_fill, (!skid_vld && req.valid && !en) |-> (rsp_vld && !rsp.ready), "skid filled without a stall")

endmodule

FILE: dv/int_divide_remainder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int_divide_remainder_unit_tb
// Drives operation codes and operand pairs into the divide unit and checks
// every quotient or remainder against a local restoring-division predictor,
// in order. Covers division by zero, signed overflow, every sign pairing,
// random operands, random stalls on both channels, a long output stall that
// backs up the pipe, and idle-free streaming at the end.
// ----------------------------------------------------------------------------
module int_divide_remainder_unit_tb;

  localparam int unsigned   DW         = idru_pkg::DW;
  localparam logic [DW-1:0] MOST_NEG   = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] MAX_POS    = ~MOST_NEG;
  localparam logic [DW-1:0] ALL_ONES   = '1;
  localparam int            DRAIN_CYC  = 40;
  localparam int            LONG_HOLD  = 150;
  localparam int            TIMEOUT_NS = 2_000_000;

  typedef struct {
    idru_pkg::func_t fn;
    logic [DW-1:0]   dividend;
    logic [DW-1:0]   divisor;
  } div_req_t;

  typedef struct {
    div_req_t      req;
    logic [DW-1:0] result;
  } div_result_t;

  logic clk = 1'b0;
  logic rst;

  idru_req_if req_ch ();
  idru_rsp_if rsp_ch ();

  int_divide_remainder_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  div_req_t    pending_divs[$];
  div_result_t expected_results[$];
  div_req_t    send_item;
  div_req_t    seen_req;
  div_result_t oldest_result;

  int n_queued   = 0;
  int n_accepted = 0;
  int n_checked  = 0;
  int n_fail     = 0;
  int send_gap   = 0;
  int hold_left  = 0;
  bit idle_on    = 1'b1;
  bit long_hold_arm = 1'b0;
  bit req_fire   = 1'b0;

  // Free-running clock, 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Restoring division at DW bits with RISC-V sign and divide-by-zero rules
  function automatic logic [DW-1:0] div_rem_predict(idru_pkg::func_t fn,
                                                     logic [DW-1:0] a,
                                                     logic [DW-1:0] b);
    logic          want_rem;
    logic          a_neg;
    logic          b_neg;
    logic          carry;
    logic [DW-1:0] n;
    logic [DW-1:0] d;
    logic [DW-1:0] rem;
    logic [DW-1:0] quo;
    want_rem = (fn == idru_pkg::FN_REMU) || (fn == idru_pkg::FN_REM);
    if (b == '0) begin
      return want_rem ? a : ALL_ONES;
    end
    a_neg = ((fn == idru_pkg::FN_DIV) || (fn == idru_pkg::FN_REM)) && a[DW-1];
    b_neg = ((fn == idru_pkg::FN_DIV) || (fn == idru_pkg::FN_REM)) && b[DW-1];
    n   = a_neg ? -a : a;
    d   = b_neg ? -b : b;
    rem = '0;
    quo = '0;
    for (int k = 0; k < DW; k++) begin
      // carry out of the doubled remainder forces the subtract
      carry = rem[DW-1];
      rem   = {rem[DW-2:0], n[DW-1]};
      n     = n << 1;
      quo   = quo << 1;
      if (carry || rem >= d) begin
        rem    = rem - d;
        quo[0] = 1'b1;
      end
    end
    if (want_rem) begin
      return a_neg ? -rem : rem;
    end
    return (a_neg ^ b_neg) ? -quo : quo;
  endfunction

  // Operand mix: full random, small, edges, sparse and one-hot values
  function automatic logic [DW-1:0] pick_operand();
    logic [DW-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4: v = $urandom_range(0, 15);
      5: v = -DW'($urandom_range(1, 16));
      6: begin
        case ($urandom_range(0, 4))
          0: v = '0;
          1: v = 1;
          2: v = ALL_ONES;
          3: v = MOST_NEG;
          default: v = MAX_POS;
        endcase
      end
      7: v = $urandom >> $urandom_range(0, 31);
      8: v = DW'(1) << $urandom_range(0, 31);
      default: v = ~($urandom >> $urandom_range(0, 31));
    endcase
    return v;
  endfunction

  task automatic queue_div(idru_pkg::func_t fn, logic [DW-1:0] a, logic [DW-1:0] b);
    div_req_t r;
    r.fn       = fn;
    r.dividend = a;
    r.divisor  = b;
    pending_divs.push_back(r);
    n_queued++;
  endtask

  task automatic queue_random(int count);
    idru_pkg::func_t fn;
    logic [DW-1:0]   a;
    logic [DW-1:0]   b;
    for (int i = 0; i < count; i++) begin
      fn = idru_pkg::func_t'($urandom_range(0, 3));
      a  = pick_operand();
      b  = pick_operand();
      // sprinkle in the signed overflow pair
      if ($urandom_range(0, 31) == 0) begin
        a = MOST_NEG;
        b = ALL_ONES;
      end
      queue_div(fn, a, b);
    end
  endtask

  // Wait until every queued beat has been answered, then resume at a rising edge
  task automatic wait_drained();
    while (n_checked != n_queued) @(negedge clk);
    @(posedge clk);
  endtask

  // Request driver: hold a beat until taken, insert idle bursts between beats
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_fire) begin
      if (send_gap > 0) begin
        req_ch.valid <= 1'b0;
        send_gap--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        req_ch.valid <= 1'b0;
        send_gap = $urandom_range(0, 4);
      end else if (pending_divs.size() > 0) begin
        send_item = pending_divs.pop_front();
        req_ch.func     <= send_item.fn;
        req_ch.dividend <= send_item.dividend;
        req_ch.divisor  <= send_item.divisor;
        req_ch.valid    <= 1'b1;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Response ready: random stall bursts, plus one long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left--;
    end else if (long_hold_arm) begin
      long_hold_arm = 1'b0;
      hold_left     = LONG_HOLD - 1;
      rsp_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      hold_left = $urandom_range(0, 4);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Record accepted requests and check each response beat against the oldest
  always @(posedge clk) begin
    req_fire = !rst && req_ch.valid && req_ch.ready;
    if (req_fire) begin
      seen_req.fn       = idru_pkg::func_t'(req_ch.func);
      seen_req.dividend = req_ch.dividend;
      seen_req.divisor  = req_ch.divisor;
      expected_results.push_back('{seen_req,
          div_rem_predict(seen_req.fn, seen_req.dividend, seen_req.divisor)});
      n_accepted++;
    end
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result: no beat outstanding, actual %h", rsp_ch.result);
        n_fail++;
      end else begin
        oldest_result = expected_results.pop_front();
        n_checked++;
        if (rsp_ch.result !== oldest_result.result) begin
          $error("result mismatch (%s %h, %h): expected %h, actual %h",
                 oldest_result.req.fn.name(), oldest_result.req.dividend,
                 oldest_result.req.divisor, oldest_result.result, rsp_ch.result);
          n_fail++;
        end
      end
    end
  end

  // Stimulus sequence
  initial begin
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.func     = idru_pkg::FN_DIVU;
    req_ch.dividend = '0;
    req_ch.divisor  = '0;
    rsp_ch.ready    = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes
    queue_div(idru_pkg::FN_DIVU, ALL_ONES, 1);
    queue_div(idru_pkg::FN_DIVU, ALL_ONES, ALL_ONES);
    queue_div(idru_pkg::FN_REMU, ALL_ONES, MOST_NEG);
    queue_div(idru_pkg::FN_DIVU, '0, ALL_ONES);
    queue_div(idru_pkg::FN_REMU, MAX_POS, MAX_POS);
    queue_div(idru_pkg::FN_REMU, 5, ALL_ONES - 1);
    // directed: quotient and remainder by zero
    queue_div(idru_pkg::FN_DIVU, 32'hDEAD_BEEF, '0);
    queue_div(idru_pkg::FN_REMU, 32'hDEAD_BEEF, '0);
    queue_div(idru_pkg::FN_DIV,  32'hDEAD_BEEF, '0);
    queue_div(idru_pkg::FN_REM,  32'hDEAD_BEEF, '0);
    queue_div(idru_pkg::FN_DIV,  MOST_NEG, '0);
    queue_div(idru_pkg::FN_REM,  '0, '0);
    // directed: most negative over minus one
    queue_div(idru_pkg::FN_DIV, MOST_NEG, ALL_ONES);
    queue_div(idru_pkg::FN_REM, MOST_NEG, ALL_ONES);
    // directed: every sign pairing
    queue_div(idru_pkg::FN_DIV, -DW'(7), 2);
    queue_div(idru_pkg::FN_REM, -DW'(7), 2);
    queue_div(idru_pkg::FN_DIV, 7, -DW'(2));
    queue_div(idru_pkg::FN_REM, 7, -DW'(2));
    queue_div(idru_pkg::FN_DIV, -DW'(7), -DW'(2));
    queue_div(idru_pkg::FN_REM, -DW'(7), -DW'(2));
    queue_div(idru_pkg::FN_DIV, MAX_POS, MOST_NEG);
    queue_div(idru_pkg::FN_REM, MOST_NEG, MOST_NEG);
    queue_div(idru_pkg::FN_DIV, MOST_NEG, 1);
    queue_div(idru_pkg::FN_DIVU, MOST_NEG, ALL_ONES);
    // pause the sender until the pipe is empty
    wait_drained();

    // random with idling, one long output stall to back up the pipe
    queue_random(600);
    while (n_accepted < n_queued - 450) @(posedge clk);
    long_hold_arm = 1'b1;
    wait_drained();
    queue_random(200);
    wait_drained();

    // streaming tail with no idling on either side
    idle_on = 1'b0;
    queue_random(500);
    wait_drained();
    repeat (DRAIN_CYC) @(posedge clk);

    if (n_fail == 0) begin
      $display("** int_divide_remainder_unit: PASSED **");
    end else begin
      $display("** int_divide_remainder_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("** int_divide_remainder_unit: FAILED **");
    $finish;
  end

endmodule
